@@ hw/rtl/ptts_pkg.sv @@
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

  typedef enum logic [1:0] {
    OpTick     = 2'd0,
    OpAdd      = 2'd1,
    OpDelete   = 2'd2,
    OpDispatch = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StAdded    = 3'd0,
    StFull     = 3'd1,
    StDeleted  = 3'd2,
    StNotFound = 3'd3,
    StTickDone = 3'd4,
    StRun      = 3'd5,
    StNothing  = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    SIdle = 3'd0,
    SAdd  = 3'd1,
    SDel  = 3'd2,
    SRead = 3'd3,
    SProc = 3'd4,
    SDone = 3'd5
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] task_tag;
    logic [31:0] initial_delay;
    logic [31:0] repeat_period;
    logic [4:0]  target_id;
  } in_word_t;

  typedef struct packed {
    status_e     status;
    logic [4:0]  task_id;
    logic [15:0] run_tag;
    logic        last;
  } res_word_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  pending;
  } entry_t;

  // slot update decision
  typedef struct packed {
    logic wr;
    logic clr;
    logic due;
  } upd_t;

  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW    = 5;
  localparam logic [7:0]  PendMax    = 8'd255;

endpackage

@@ hw/rtl/ptts_table.sv @@
// ----------------------------------------------------------------------------
// ptts_table
// Task slot memory with registered read, plus per-slot valid flags.
// ----------------------------------------------------------------------------
module ptts_table #(
  parameter int unsigned TASK_SLOTS = 16,
  parameter int unsigned IdxW       = 4
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_idx_i,
  input  ptts_pkg::entry_t       wr_data_i,
  input  logic [IdxW-1:0]        rd_idx_i,
  output ptts_pkg::entry_t       rd_data_o,
  input  logic                   vld_set_i,
  input  logic                   vld_clr_i,
  input  logic [IdxW-1:0]        vld_idx_i,
  output logic [TASK_SLOTS-1:0]  valid_o
);

  ptts_pkg::entry_t      mem_q [TASK_SLOTS];
  ptts_pkg::entry_t      rd_data_q;
  logic [TASK_SLOTS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_idx_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (vld_set_i) begin
      valid_q[vld_idx_i] <= 1'b1;
    end else if (vld_clr_i) begin
      valid_q[vld_idx_i] <= 1'b0;
    end
  end

  assign rd_data_o = rd_data_q;
  assign valid_o   = valid_q;

endmodule

@@ hw/rtl/ptts_slot_upd.sv @@
// ----------------------------------------------------------------------------
// ptts_slot_upd
// Shared slot update unit: countdown/reload on tick, run check on dispatch.
// ----------------------------------------------------------------------------
module ptts_slot_upd (
  input  ptts_pkg::op_e    op_i,
  input  logic             valid_i,
  input  ptts_pkg::entry_t ent_i,
  output ptts_pkg::entry_t ent_o,
  output ptts_pkg::upd_t   upd_o
);

  always_comb begin
    ent_o = ent_i;
    upd_o = '0;
    if (valid_i) begin
      case (op_i)
        ptts_pkg::OpTick: begin
          upd_o.wr = 1'b1;
          if (ent_i.delay != 32'd0) begin
            ent_o.delay = ent_i.delay - 32'd1;
          end else begin
            ent_o.delay = ent_i.period;
            if (ent_i.pending != ptts_pkg::PendMax) begin
              ent_o.pending = ent_i.pending + 8'd1;
            end
          end
        end
        ptts_pkg::OpDispatch: begin
          if (ent_i.pending != 8'd0) begin
            upd_o.due     = 1'b1;
            upd_o.wr      = 1'b1;
            upd_o.clr     = (ent_i.period == 32'd0);
            ent_o.pending = ent_i.pending - 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/periodic_task_tick_scheduler.sv @@
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Cooperative task table: add, delete, tick and dispatch of periodic tasks.
// ----------------------------------------------------------------------------
// A command word on cmd_i is taken at a rising edge with start high and busy
// low; busy falls in the cycle the last result word is on result_o. Result
// words appear on result_o for one cycle each, flagged by result_valid_o,
// and the last word of a command carries last = 1. The receiver cannot stall.
// Delete gives one word; add scans the valid flags from slot 0 for the first
// free slot; tick walks every slot; dispatch walks the slots and stops early
// once 16 runs are found. A new command can be taken in the cycle the last
// word is on result_o. Tick and dispatch walk the slots one at a time through
// the slot memory, reading each slot in state SRead and updating it in SProc.
// Run words of a dispatch come out as due slots are found, one behind, so the
// final one can be flagged last. Reset empties the table at once by clearing
// the valid flags; the block is idle and ready as soon as reset is released.
// ----------------------------------------------------------------------------
module periodic_task_tick_scheduler #(
  parameter int unsigned TASK_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  ptts_pkg::in_word_t  cmd_i,
  output logic                result_valid_o,
  output ptts_pkg::res_word_t result_o
);

  localparam int unsigned    IdxW    = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TASK_SLOTS - 1);

  ptts_pkg::state_e    state_q, state_d;
  ptts_pkg::in_word_t  cmd_q;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [ptts_pkg::ResCntW-1:0] cnt_q, cnt_d;
  logic                hold_vld_q, hold_vld_d;
  logic [4:0]          hold_id_q, hold_id_d;
  logic [15:0]         hold_tag_q, hold_tag_d;
  logic                res_vld_q, res_vld_d;
  ptts_pkg::res_word_t res_q, res_d;

  logic                  wr_en;
  ptts_pkg::entry_t      wr_data;
  ptts_pkg::entry_t      rd_data;
  ptts_pkg::entry_t      ent_new;
  ptts_pkg::upd_t        upd;
  logic                  vld_set, vld_clr;
  logic [IdxW-1:0]       vld_idx;
  logic [TASK_SLOTS-1:0] valid;

  logic [31:0]     id_wide, del_wide;
  logic [4:0]      slot_id;
  logic [IdxW-1:0] del_idx;
  logic            del_hit;
  logic            accept;

  assign accept   = start && (state_q == ptts_pkg::SIdle);
  assign id_wide  = 32'(idx_q) + 32'd1;
  assign slot_id  = id_wide[4:0];
  assign del_wide = 32'(cmd_q.target_id) - 32'd1;
  assign del_idx  = del_wide[IdxW-1:0];
  assign del_hit  = (cmd_q.target_id != 5'd0) && (32'(cmd_q.target_id) <= TASK_SLOTS)
                    && valid[del_idx];

  ptts_table #(
    .TASK_SLOTS(TASK_SLOTS),
    .IdxW      (IdxW)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_idx_i (idx_q),
    .wr_data_i(wr_data),
    .rd_idx_i (idx_q),
    .rd_data_o(rd_data),
    .vld_set_i(vld_set),
    .vld_clr_i(vld_clr),
    .vld_idx_i(vld_idx),
    .valid_o  (valid)
  );

  ptts_slot_upd u_upd (
    .op_i   (cmd_q.op),
    .valid_i(valid[idx_q]),
    .ent_i  (rd_data),
    .ent_o  (ent_new),
    .upd_o  (upd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      ptts_pkg::SIdle: begin
        idx_d = '0;
        if (start) begin
          unique case (cmd_i.op)
            ptts_pkg::OpAdd:    state_d = ptts_pkg::SAdd;
            ptts_pkg::OpDelete: state_d = ptts_pkg::SDel;
            default:            state_d = ptts_pkg::SRead;
          endcase
        end
      end
      ptts_pkg::SAdd: begin
        if (!valid[idx_q] || idx_q == LastIdx) begin
          state_d = ptts_pkg::SIdle;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ptts_pkg::SDel: state_d = ptts_pkg::SIdle;
      ptts_pkg::SRead: state_d = ptts_pkg::SProc;
      ptts_pkg::SProc: begin
        if (idx_q == LastIdx ||
            (upd.due && cnt_q == ptts_pkg::ResCntW'(ptts_pkg::MaxResults - 1))) begin
          state_d = ptts_pkg::SDone;
        end else begin
          state_d = ptts_pkg::SRead;
          idx_d   = idx_q + 1'b1;
        end
      end
      ptts_pkg::SDone: state_d = ptts_pkg::SIdle;
      default: state_d = ptts_pkg::SIdle;
    endcase
  end

  // outputs and datapath
  always_comb begin
    wr_en      = 1'b0;
    wr_data    = ent_new;
    vld_set    = 1'b0;
    vld_clr    = 1'b0;
    vld_idx    = idx_q;
    cnt_d      = cnt_q;
    hold_vld_d = hold_vld_q;
    hold_id_d  = hold_id_q;
    hold_tag_d = hold_tag_q;
    res_vld_d  = 1'b0;
    res_d      = '0;
    unique case (state_q)
      ptts_pkg::SIdle: begin
        if (accept) begin
          cnt_d      = '0;
          hold_vld_d = 1'b0;
        end
      end
      ptts_pkg::SAdd: begin
        if (!valid[idx_q]) begin
          wr_en           = 1'b1;
          wr_data.tag     = cmd_q.task_tag;
          wr_data.delay   = cmd_q.initial_delay;
          wr_data.period  = cmd_q.repeat_period;
          wr_data.pending = 8'd0;
          vld_set         = 1'b1;
          res_vld_d       = 1'b1;
          res_d.status    = ptts_pkg::StAdded;
          res_d.task_id   = slot_id;
          res_d.last      = 1'b1;
        end else if (idx_q == LastIdx) begin
          res_vld_d    = 1'b1;
          res_d.status = ptts_pkg::StFull;
          res_d.last   = 1'b1;
        end
      end
      ptts_pkg::SDel: begin
        vld_idx      = del_idx;
        vld_clr      = del_hit;
        res_vld_d    = 1'b1;
        res_d.status = del_hit ? ptts_pkg::StDeleted : ptts_pkg::StNotFound;
        res_d.last   = 1'b1;
      end
      ptts_pkg::SRead: ;
      ptts_pkg::SProc: begin
        wr_en   = upd.wr;
        vld_clr = upd.clr;
        if (upd.due) begin
          if (hold_vld_q) begin
            res_vld_d     = 1'b1;
            res_d.status  = ptts_pkg::StRun;
            res_d.task_id = hold_id_q;
            res_d.run_tag = hold_tag_q;
          end
          hold_vld_d = 1'b1;
          hold_id_d  = slot_id;
          hold_tag_d = rd_data.tag;
          cnt_d      = cnt_q + 1'b1;
        end
      end
      ptts_pkg::SDone: begin
        res_vld_d  = 1'b1;
        res_d.last = 1'b1;
        if (cmd_q.op == ptts_pkg::OpTick) begin
          res_d.status = ptts_pkg::StTickDone;
        end else if (hold_vld_q) begin
          res_d.status  = ptts_pkg::StRun;
          res_d.task_id = hold_id_q;
          res_d.run_tag = hold_tag_q;
        end else begin
          res_d.status = ptts_pkg::StNothing;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ptts_pkg::SIdle;
      idx_q      <= '0;
      cnt_q      <= '0;
      hold_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      cnt_q      <= cnt_d;
      hold_vld_q <= hold_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
    hold_id_q  <= hold_id_d;
    hold_tag_q <= hold_tag_d;
    res_q      <= res_d;
  end

  assign busy           = (state_q != ptts_pkg::SIdle);
  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after command");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy)
    else $error("still busy after last word");

  a_only_runs_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> result_o.status == ptts_pkg::StRun)
    else $error("non-run word without last");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ptts_pkg::ResCntW'(ptts_pkg::MaxResults))
    else $error("too many run words");

endmodule
